@@ hw/rtl/gf2hd_pkg.sv @@
package gf2hd_pkg;

   // Default and limits of the sequence length.
   localparam int SEQ_LEN_DEFAULT = 64;
   localparam int LEN_MIN = 4;
   localparam int LEN_W = 7;
   localparam int ROW_W = 64;
   localparam int JNUM_W = 6;
   localparam int MAT_N = 32;
   localparam int MIDX_W = 5;

   typedef enum logic [2:0] {
      S_LOAD,
      S_ROW0,
      S_ROW1,
      S_MAT,
      S_ELIM,
      S_ROWOUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic emit0;
      logic emit1;
      logic mat_load;
      logic elim_step;
      logic pos_done;
      logic emit_row;
      logic row_next;
      logic clear_seq;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_bit;
      logic pivot_none;
      logic col_last;
      logic pos_last;
      logic row_last;
   } status_type;

endpackage

@@ hw/rtl/gf2_hankel_determinant_table.sv @@
// The bit that completes a sequence moves the sequencer through S_ROW0 and S_ROW1, which emit
// rows 0 and 1; each row j of order two or more is then built from matrix loads and eliminations.
// Elimination handles one column per cycle in one shared matrix unit, and a new sequence is
// taken only after the final row. Results come one beat per row.
// The receiver cannot stall. Synchronous reset sets length 64 and clears the sequence.
module gf2_hankel_determinant_table #(
   parameter int SEQ_LEN = gf2hd_pkg::SEQ_LEN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_seq_bit,
   input  logic                             csr_write_enable,
   input  logic [gf2hd_pkg::LEN_W-1:0]      csr_write_data,
   output logic                             rsp_strobe,
   output logic [gf2hd_pkg::JNUM_W-1:0]     rsp_row_number,
   output logic [gf2hd_pkg::ROW_W-1:0]      rsp_row_bits,
   output logic                             rsp_final_row
);

   gf2hd_pkg::cmd_type    cmd;
   gf2hd_pkg::status_type status;

   // Sequencer.
   gf2hd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Store, elimination unit and result registers.
   gf2hd_datapath #(
      .SEQ_LEN (SEQ_LEN)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .seq_bit          (req_seq_bit),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_row_number   (rsp_row_number),
      .rsp_row_bits     (rsp_row_bits),
      .rsp_final_row    (rsp_final_row)
   );

`ifndef SYNTH
   // A result beat other than the final row only appears while a table is in progress.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_final_row) |-> busy) else $error("result beat while idle");

   // Row 0 is always followed directly by row 1.
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_row_number == '0) |=> (rsp_strobe && rsp_row_number == 6'd1))
      else $error("row 1 does not follow row 0");

   // After the final row the block takes the next sequence.
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_final_row) |-> !busy) else $error("busy after final row");
`endif

endmodule

@@ hw/rtl/gf2hd_ctrl.sv @@
module gf2hd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  gf2hd_pkg::status_type status,
   output gf2hd_pkg::cmd_type    cmd,
   output logic                  busy
);

   gf2hd_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gf2hd_pkg::S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gf2hd_pkg::S_LOAD: begin
            if (start && status.last_bit) state_in = gf2hd_pkg::S_ROW0;
         end
         gf2hd_pkg::S_ROW0: state_in = gf2hd_pkg::S_ROW1;
         gf2hd_pkg::S_ROW1: state_in = gf2hd_pkg::S_MAT;
         gf2hd_pkg::S_MAT: state_in = gf2hd_pkg::S_ELIM;
         gf2hd_pkg::S_ELIM: begin
            if (status.pivot_none || status.col_last) begin
               state_in = status.pos_last ? gf2hd_pkg::S_ROWOUT : gf2hd_pkg::S_MAT;
            end
         end
         gf2hd_pkg::S_ROWOUT: begin
            state_in = status.row_last ? gf2hd_pkg::S_LOAD : gf2hd_pkg::S_MAT;
         end
         default: state_in = gf2hd_pkg::S_LOAD;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         gf2hd_pkg::S_LOAD: cmd.accept = start;
         gf2hd_pkg::S_ROW0: cmd.emit0 = 1'b1;
         gf2hd_pkg::S_ROW1: cmd.emit1 = 1'b1;
         gf2hd_pkg::S_MAT: cmd.mat_load = 1'b1;
         gf2hd_pkg::S_ELIM: begin
            cmd.elim_step = 1'b1;
            cmd.pos_done = status.pivot_none || status.col_last;
         end
         gf2hd_pkg::S_ROWOUT: begin
            cmd.emit_row = 1'b1;
            cmd.row_next = !status.row_last;
            cmd.clear_seq = status.row_last;
         end
         default: cmd = '0;
      endcase
   end

   assign busy = (state_ff != gf2hd_pkg::S_LOAD);

endmodule

@@ hw/rtl/gf2hd_datapath.sv @@
module gf2hd_datapath #(
   parameter int SEQ_LEN = gf2hd_pkg::SEQ_LEN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gf2hd_pkg::cmd_type               cmd,
   input  logic                             seq_bit,
   input  logic                             csr_write_enable,
   input  logic [gf2hd_pkg::LEN_W-1:0]      csr_write_data,
   output gf2hd_pkg::status_type            status,
   output logic                             rsp_strobe,
   output logic [gf2hd_pkg::JNUM_W-1:0]     rsp_row_number,
   output logic [gf2hd_pkg::ROW_W-1:0]      rsp_row_bits,
   output logic                             rsp_final_row
);

   localparam int N = gf2hd_pkg::MAT_N;
   localparam int MW = gf2hd_pkg::MIDX_W;
   localparam int LW = gf2hd_pkg::LEN_W;
   localparam int JW = gf2hd_pkg::JNUM_W;
   localparam int RW = gf2hd_pkg::ROW_W;

   logic [LW-1:0] length_ff;
   logic [RW-1:0] seq_ff;
   logic [LW-1:0] count_ff;
   logic [JW-1:0] j_ff;
   logic [JW-1:0] s_ff;
   logic [MW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [N-1:0]  mat_ff [N];
   logic          strobe_ff;
   logic [JW-1:0] number_ff;
   logic [RW-1:0] bits_ff;
   logic          final_ff;

   logic [LW-1:0] len_eff;
   logic [LW-1:0] top;
   logic [RW-1:0] window;
   logic [N-1:0]  col_mask;
   logic [N-1:0]  mat_in [N];
   logic [MW-1:0] pivot;
   logic          found;
   logic [JW-1:0] bit_pos;

   // Clamp the programmed length into its legal range.
   always_comb begin
      len_eff = length_ff;
      if (length_ff < LW'(gf2hd_pkg::LEN_MIN)) len_eff = LW'(gf2hd_pkg::LEN_MIN);
      if (length_ff > LW'(SEQ_LEN)) len_eff = LW'(SEQ_LEN);
   end
   assign top = (len_eff + LW'(1)) >> 1;

   // Hankel window for the current start position.
   assign window = seq_ff >> s_ff;
   assign col_mask = {N{1'b1}} >> (JW'(N) - j_ff);

   // Pivot search in the current column.
   always_comb begin
      found = 1'b0;
      pivot = '0;
      for (int r = N - 1; r >= 0; r--) begin
         if ((MW'(r) >= col_ff) && mat_ff[r][col_ff]) begin
            found = 1'b1;
            pivot = MW'(r);
         end
      end
   end

   // Row swap and elimination below the pivot.
   always_comb begin
      logic [N-1:0] base;
      for (int r = 0; r < N; r++) begin
         if (MW'(r) == pivot) base = mat_ff[col_ff];
         else if (MW'(r) == col_ff) base = mat_ff[pivot];
         else base = mat_ff[r];
         if ((MW'(r) > col_ff) && base[col_ff]) base = base ^ mat_ff[pivot];
         mat_in[r] = base;
      end
   end

   assign bit_pos = s_ff + j_ff - JW'(1);

   assign status.last_bit = (count_ff + LW'(1)) == len_eff;
   assign status.pivot_none = !found;
   assign status.col_last = ({1'b0, col_ff} == (j_ff - JW'(1)));
   assign status.pos_last = ({1'b0, s_ff} == (len_eff + LW'(1) - {j_ff, 1'b0}));
   assign status.row_last = ({1'b0, j_ff} == top);

   // Length register, sequence store and bit count.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LW'(64);
         seq_ff <= '0;
         count_ff <= '0;
      end else if (csr_write_enable) begin
         length_ff <= csr_write_data;
         seq_ff <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         if (seq_bit) seq_ff[count_ff[5:0]] <= 1'b1;
         count_ff <= status.last_bit ? '0 : count_ff + LW'(1);
      end else if (cmd.clear_seq) begin
         seq_ff <= '0;
      end
   end

   // Order, position, column and row accumulator.
   always_ff @(posedge clock) begin
      if (cmd.emit1 || cmd.row_next) begin
         j_ff <= cmd.emit1 ? JW'(2) : j_ff + JW'(1);
         s_ff <= '0;
         row_ff <= '0;
      end else if (cmd.pos_done) begin
         if (found) row_ff[bit_pos] <= 1'b1;
         s_ff <= s_ff + JW'(1);
      end
      if (cmd.mat_load) col_ff <= '0;
      else if (cmd.elim_step) col_ff <= col_ff + MW'(1);
   end

   // Matrix load and elimination.
   always_ff @(posedge clock) begin
      for (int r = 0; r < N; r++) begin
         if (cmd.mat_load) begin
            mat_ff[r] <= (JW'(r) < j_ff) ? (window[r +: N] & col_mask) : '0;
         end else if (cmd.elim_step) begin
            mat_ff[r] <= mat_in[r];
         end
      end
   end

   // Result beat registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit0 || cmd.emit1 || cmd.emit_row;
      end
      if (cmd.emit0) begin
         number_ff <= '0;
         bits_ff <= {RW{1'b1}} >> (LW'(RW) - len_eff);
         final_ff <= 1'b0;
      end else if (cmd.emit1) begin
         number_ff <= JW'(1);
         bits_ff <= seq_ff;
         final_ff <= 1'b0;
      end else if (cmd.emit_row) begin
         number_ff <= j_ff;
         bits_ff <= row_ff;
         final_ff <= status.row_last;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_row_number = number_ff;
   assign rsp_row_bits = bits_ff;
   assign rsp_final_row = final_ff;

endmodule
